FILE: rtl/core/trsm_pkg.sv
// shared types, codes and helpers for the tcp receive state machine
`timescale 1ns / 1ps
`default_nettype none

package trsm_pkg;

	typedef enum logic [3:0] {
		ST_CLOSED     = 4'd0,
		ST_LISTEN     = 4'd1,
		ST_SYN_SENT   = 4'd2,
		ST_SYN_RECV   = 4'd3,
		ST_EST        = 4'd4,
		ST_CLOSE_WAIT = 4'd5,
		ST_LAST_ACK   = 4'd6,
		ST_FW1        = 4'd7,
		ST_FW2        = 4'd8,
		ST_OTHER      = 4'd9
	} conn_state_t;

	localparam logic [5:0] FLAG_FIN = 6'd1;
	localparam logic [5:0] FLAG_SYN = 6'd2;
	localparam logic [5:0] FLAG_ACK = 6'd16;
	localparam logic [5:0] FLAG_NONE = 6'd0;
	localparam logic [5:0] FLAG_SYN_ACK = FLAG_SYN | FLAG_ACK;
	localparam logic [5:0] FLAG_FIN_ACK = FLAG_FIN | FLAG_ACK;

	localparam logic [3:0] WAKE_SEND    = 4'b0001;
	localparam logic [3:0] WAKE_CONNECT = 4'b0010;
	localparam logic [3:0] WAKE_ACCEPT  = 4'b0100;
	localparam logic [3:0] WAKE_RECEIVE = 4'b1000;
	localparam logic [3:0] WAKE_NONE    = 4'b0000;

	// configuration register indexes
	localparam logic [1:0] CFG_OPEN_MODE   = 2'd0;
	localparam logic [1:0] CFG_INIT_SEQ    = 2'd1;
	localparam logic [1:0] CFG_RCV_WINDOW  = 2'd2;
	localparam logic [1:0] CFG_DEF_WINDOW  = 2'd3;

	localparam int SEG_BITS = 102;
	localparam int SEG_BYTES_BITS = 104;
	localparam int RES_BITS = 145;
	localparam int RES_BYTES_BITS = 152;

	typedef struct packed {
		logic [15:0] payload_len;
		logic [15:0] seg_window;
		logic [31:0] seg_ack;
		logic [31:0] seg_seq;
		logic [5:0]  seg_flags;
	} seg_t;

	typedef struct packed {
		conn_state_t open_mode;
		logic [31:0] initial_send_seq;
		logic [15:0] receive_window;
		logic [15:0] default_send_window;
	} cfg_t;

	typedef struct packed {
		conn_state_t conn_state;
		logic [31:0] rcv_next;
		logic [31:0] snd_una;
		logic [31:0] snd_next;
		logic [15:0] snd_window;
	} ctx_t;

	// packed from the lowest bit up: send_flags first
	typedef struct packed {
		logic        unexpected;
		logic        child_spawned;
		logic [3:0]  wake_events;
		logic        reset_out;
		logic [15:0] accepted_len;
		logic [15:0] send_window;
		logic [31:0] send_next;
		logic [31:0] send_unacked;
		logic [31:0] rcv_next;
		logic [3:0]  conn_state;
		logic [5:0]  send_flags;
	} res_t;

	// a <= b in serial arithmetic
	function automatic logic ser_le(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = b - a;
		return ~d[31];
	endfunction

	// a < b in serial arithmetic
	function automatic logic ser_lt(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = b - a;
		return (d != 32'd0) && ~d[31];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/trsm_ctx.sv
// connection context and configuration registers
`timescale 1ns / 1ps
`default_nettype none

module trsm_ctx (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire  [1:0]           cfg_index,
	input  wire  [31:0]          cfg_data,
	input  wire                  upd_en,
	input  trsm_pkg::ctx_t       ctx_next,
	output trsm_pkg::ctx_t       ctx,
	output trsm_pkg::cfg_t       cfg
);
	import trsm_pkg::*;

	ctx_t ctx_q;
	cfg_t cfg_q;
	conn_state_t mode_clamped;

	// out-of-range modes load as other
	always_comb begin
		if (cfg_data[3:0] > ST_OTHER) begin
			mode_clamped = ST_OTHER;
		end else begin
			mode_clamped = conn_state_t'(cfg_data[3:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_mode           <= ST_CLOSED;
			cfg_q.initial_send_seq    <= 32'd0;
			cfg_q.receive_window      <= 16'hFFFF;
			cfg_q.default_send_window <= 16'hFFFF;
			ctx_q.conn_state          <= ST_CLOSED;
			ctx_q.rcv_next            <= 32'd0;
			ctx_q.snd_una             <= 32'd0;
			ctx_q.snd_next            <= 32'd0;
			ctx_q.snd_window          <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OPEN_MODE: begin
					cfg_q.open_mode  <= mode_clamped;
					ctx_q.conn_state <= mode_clamped;
				end
				CFG_INIT_SEQ: begin
					cfg_q.initial_send_seq <= cfg_data;
					ctx_q.snd_una          <= cfg_data;
					ctx_q.snd_next         <= cfg_data;
				end
				CFG_RCV_WINDOW: begin
					cfg_q.receive_window <= cfg_data[15:0];
				end
				CFG_DEF_WINDOW: begin
					cfg_q.default_send_window <= cfg_data[15:0];
					ctx_q.snd_window          <= cfg_data[15:0];
				end
				default: begin
				end
			endcase
		end else if (upd_en) begin
			ctx_q <= ctx_next;
		end
	end

	assign ctx = ctx_q;
	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/trsm_step.sv
// per-segment state transition and result logic
`timescale 1ns / 1ps
`default_nettype none

module trsm_step (
	input  trsm_pkg::seg_t       seg,
	input  trsm_pkg::ctx_t       ctx,
	input  trsm_pkg::cfg_t       cfg,
	output trsm_pkg::ctx_t       ctx_next,
	output trsm_pkg::res_t       res,
	output logic                 dual
);
	import trsm_pkg::*;

	logic        win_ok;
	logic [3:0]  wu_wake;
	logic [15:0] win_upd;
	logic [31:0] seq_p1;
	logic [31:0] seq_pl;
	logic        syn_match;
	logic [5:0]  sf;
	logic [3:0]  wake;
	logic [15:0] acc;
	logic        rst;
	logic        unexp;
	logic        child;

	// window update only when ack lies within [snd_una, snd_next]
	assign win_ok  = ser_le(ctx.snd_una, seg.seg_ack) && ser_le(seg.seg_ack, ctx.snd_next);
	assign wu_wake = (win_ok && ctx.snd_window == 16'd0) ? WAKE_SEND : WAKE_NONE;
	assign win_upd = win_ok ? seg.seg_window : ctx.snd_window;
	assign seq_p1  = seg.seg_seq + 32'd1;
	assign seq_pl  = seg.seg_seq + {16'd0, seg.payload_len};
	assign syn_match = (seg.seg_flags == FLAG_SYN) || (seg.seg_flags == FLAG_SYN_ACK);

	always_comb begin
		ctx_next = ctx;
		sf       = FLAG_NONE;
		wake     = WAKE_NONE;
		acc      = 16'd0;
		rst      = 1'b0;
		unexp    = 1'b0;
		child    = 1'b0;
		dual     = 1'b0;
		case (ctx.conn_state)
			ST_LISTEN: begin
				if (syn_match) begin
					child = 1'b1;
					sf    = FLAG_SYN_ACK;
				end
			end
			ST_SYN_SENT: begin
				if (syn_match) begin
					ctx_next.snd_una    = seg.seg_ack;
					ctx_next.snd_next   = seg.seg_ack;
					ctx_next.rcv_next   = seq_p1;
					ctx_next.conn_state = ST_EST;
					sf   = FLAG_ACK;
					wake = WAKE_CONNECT;
				end else begin
					unexp = 1'b1;
				end
			end
			ST_SYN_RECV: begin
				if (seg.seg_flags == FLAG_ACK) begin
					ctx_next.snd_una    = seg.seg_ack;
					ctx_next.conn_state = ST_EST;
					wake = WAKE_ACCEPT;
				end else begin
					unexp = 1'b1;
				end
			end
			ST_EST: begin
				ctx_next.snd_window = win_upd;
				wake = wu_wake;
				if (seg.seg_flags == FLAG_FIN) begin
					ctx_next.rcv_next   = seq_p1;
					ctx_next.conn_state = ST_CLOSE_WAIT;
					wake = wu_wake | WAKE_RECEIVE;
					sf   = FLAG_FIN_ACK;
					dual = 1'b1;
				end else if ((seg.seg_flags & FLAG_ACK) != FLAG_NONE &&
						seg.payload_len != 16'd0) begin
					if (seg.payload_len > cfg.receive_window) begin
						rst = 1'b1;
					end else begin
						acc = seg.payload_len;
						ctx_next.rcv_next = seq_pl;
						ctx_next.snd_una  = seg.seg_ack;
						ctx_next.snd_next = seg.seg_ack;
						sf   = FLAG_ACK;
						wake = wu_wake | WAKE_RECEIVE;
					end
				end else if ((seg.seg_flags & FLAG_ACK) != FLAG_NONE) begin
					if (ser_lt(ctx.snd_una, seg.seg_ack) &&
							ser_le(seg.seg_ack, ctx.snd_next)) begin
						ctx_next.snd_una = seg.seg_ack;
					end
				end
			end
			ST_LAST_ACK: begin
				if (seg.seg_flags == FLAG_ACK) begin
					ctx_next.conn_state = ST_CLOSED;
				end else begin
					unexp = 1'b1;
				end
			end
			ST_FW1: begin
				if (seg.seg_flags == FLAG_ACK || seg.seg_flags == FLAG_FIN ||
						seg.seg_flags == FLAG_FIN_ACK) begin
					ctx_next.rcv_next   = seq_p1;
					ctx_next.snd_window = win_upd;
					ctx_next.conn_state = ST_FW2;
					wake = wu_wake;
				end else begin
					unexp = 1'b1;
				end
			end
			ST_FW2: begin
				if (seg.seg_flags == FLAG_FIN_ACK) begin
					ctx_next.rcv_next   = seq_p1;
					ctx_next.snd_window = win_upd;
					sf   = FLAG_ACK;
					wake = wu_wake | WAKE_RECEIVE;
				end else begin
					unexp = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// a spawned child reports its own values, the listener stays put
	always_comb begin
		res.send_flags    = sf;
		res.accepted_len  = acc;
		res.reset_out     = rst;
		res.wake_events   = wake;
		res.child_spawned = child;
		res.unexpected    = unexp;
		if (child) begin
			res.conn_state   = ST_SYN_RECV;
			res.rcv_next     = seq_p1;
			res.send_unacked = cfg.initial_send_seq;
			res.send_next    = cfg.initial_send_seq;
			res.send_window  = cfg.default_send_window;
		end else begin
			res.conn_state   = ctx_next.conn_state;
			res.rcv_next     = ctx_next.rcv_next;
			res.send_unacked = ctx_next.snd_una;
			res.send_next    = ctx_next.snd_next;
			res.send_window  = ctx_next.snd_window;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/trsm_out.sv
// result register, replays the leading ack of a two-result segment
`timescale 1ns / 1ps
`default_nettype none

module trsm_out (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  load,
	input  trsm_pkg::res_t       res_in,
	input  wire                  dual_in,
	output logic                 can_load,
	output logic                 out_valid,
	input  wire                  out_ready,
	output trsm_pkg::res_t       res_out,
	output logic                 out_last
);
	import trsm_pkg::*;

	logic valid_q;
	logic dual_q;
	res_t res_q;
	logic take;

	assign take     = valid_q && out_ready;
	assign can_load = !valid_q || (take && !dual_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dual_q  <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			dual_q  <= dual_in;
		end else if (take) begin
			if (dual_q) begin
				dual_q <= 1'b0;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	// leading result of a pair: plain ack, no wake events
	always_comb begin
		res_out = res_q;
		if (dual_q) begin
			res_out.send_flags  = FLAG_ACK;
			res_out.wake_events = WAKE_NONE;
		end
	end

	assign out_valid = valid_q;
	assign out_last  = !dual_q;

	ap_dual_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dual_q |-> valid_q && res_q.conn_state == ST_CLOSE_WAIT)
		else $error("pending pair without a valid result");

	ap_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !valid_q || (out_ready && !dual_q))
		else $error("result register overwritten before delivery");

	ap_pair_second: assert property (@(posedge clk) disable iff (!arst_n)
		take && dual_q |=> valid_q && !dual_q)
		else $error("second result of a pair lost");

endmodule

`default_nettype wire

FILE: rtl/core/tcp_receive_state_machine.sv
// top level of the tcp receive state machine
`timescale 1ns / 1ps
`default_nettype none

// Receive side of one TCP connection. Each request on the s_axis side is one
// segment header; the block updates its connection state, rcv_next, snd_una,
// snd_next and send window, and answers on the m_axis side with one result,
// or two when ESTABLISHED takes a bare FIN (a plain ACK first, then FIN|ACK
// with tlast high). A segment is registered on entry and processed by
// single-level logic into the result register; one segment can be taken every
// cycle while m_axis_tready is high and no result pair is pending, and a
// two-result segment holds the result register until both are taken. The
// context registers are the only loop. Configuration writes are taken at once
// (cfg_ready is always high) and must only be issued while the block is idle.

module tcp_receive_state_machine (
	input  wire          clk,
	input  wire          arst_n,
	// segment requests
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// seg_flags[5:0], seg_seq[37:6], seg_ack[69:38], seg_window[85:70],
	// payload_len[101:86], zero fill up to 103
	input  wire  [103:0] s_axis_tdata,
	// result requests
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// send_flags[5:0], conn_state[9:6], rcv_next[41:10], send_unacked[73:42],
	// send_next[105:74], send_window[121:106], accepted_len[137:122],
	// reset_out[138], wake_events[142:139], child_spawned[143],
	// unexpected[144], zero fill up to 151
	output logic [151:0] m_axis_tdata,
	// last_result
	output logic         m_axis_tlast,
	// configuration writes
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [1:0]   cfg_index,
	input  wire  [31:0]  cfg_data
);
	import trsm_pkg::*;

	logic valid_s1;
	seg_t seg_s1;
	logic fire;
	logic can_load;
	logic dual;
	ctx_t ctx;
	ctx_t ctx_next;
	cfg_t cfg;
	res_t res;
	res_t res_out;

	assign cfg_ready     = 1'b1;
	assign fire          = valid_s1 && can_load;
	assign s_axis_tready = !valid_s1 || fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			seg_s1 <= seg_t'(s_axis_tdata[SEG_BITS-1:0]);
		end
	end

	trsm_ctx u_ctx (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.upd_en    (fire),
		.ctx_next  (ctx_next),
		.ctx       (ctx),
		.cfg       (cfg)
	);

	trsm_step u_step (
		.seg      (seg_s1),
		.ctx      (ctx),
		.cfg      (cfg),
		.ctx_next (ctx_next),
		.res      (res),
		.dual     (dual)
	);

	trsm_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.res_in    (res),
		.dual_in   (dual),
		.can_load  (can_load),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res_out   (res_out),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {{(RES_BYTES_BITS-RES_BITS){1'b0}}, res_out};

	// a leading result is always the plain ack into close_wait
	ap_lead_ack: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |->
			res_out.send_flags == FLAG_ACK && res_out.conn_state == ST_CLOSE_WAIT)
		else $error("leading result is not a close_wait ack");

	// child results carry syn_recv and syn|ack
	ap_child: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res_out.child_spawned |->
			res_out.conn_state == ST_SYN_RECV && res_out.send_flags == FLAG_SYN_ACK)
		else $error("spawned child result malformed");

	// a segment is never processed while the listener would lose it
	ap_listen_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ctx.conn_state == ST_LISTEN |=> ctx.conn_state == ST_LISTEN || $past(cfg_valid))
		else $error("listener state changed by a segment");

endmodule

`default_nettype wire
